FILE: rtl/wdisc_point_variation_top_assert.svh
// Assertion macros for the wdisc point variation block.
// Used by the port checker; needs clk and arst_n in the including scope.
`ifndef WDISC_POINT_VARIATION_TOP_ASSERT_SVH
`define WDISC_POINT_VARIATION_TOP_ASSERT_SVH

// Check a property on every rising edge outside reset
`define WPV_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a signal holds while the output word waits
`define WPV_ASSERT_HOLD(name, sig, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) \
		(out_valid && out_stall) |=> $stable(sig)) else $error(msg);

`endif

FILE: rtl/wpv_pkg.sv
// Shared constants, types and helper functions of the wdisc point variation block.
// No dependencies; used by every RTL file of the block but wpv_delay.
`timescale 1ns / 1ps
package wpv_pkg;

	localparam int XW           = 32;
	localparam int CORDIC_STEPS = 30;
	localparam int ROOT_BITS    = 32;
	localparam int QUO_BITS     = 32;
	localparam int SQ_W         = 64;
	localparam int NUM_W        = 48;
	localparam int DEN_W        = 33;
	localparam int VEC_W        = 66;
	localparam int ROT_W        = 34;
	localparam int ANG_W        = 35;
	localparam int SUM_W        = 48;

	localparam logic [XW-1:0]           AMOUNT_RESET = 32'h0001_0000;
	localparam logic signed [ANG_W-1:0] PI_Q30       = 35'sd3373259426;
	localparam logic signed [ANG_W-1:0] HALF_PI_Q30  = 35'sd1686629713;
	localparam logic signed [29:0]      INV_PI_Q30   = 30'sd341782638;
	localparam logic signed [ROT_W-1:0] GAIN_INV_Q30 = 34'sd652032874;
	localparam logic signed [XW-1:0]    Q30_ONE      = 32'sd1073741824;

	typedef enum logic {
		CORDIC_VEC,
		CORDIC_ROT
	} cordic_mode_t;

	typedef struct packed {
		logic signed [XW-1:0] tz;
		logic signed [XW-1:0] px;
		logic signed [XW-1:0] py;
		logic signed [XW-1:0] pz;
	} payload_t;

	// arctangent of 2^-idx in Q30 radians
	function automatic logic signed [ANG_W-1:0] atan_q30(input int idx);
		logic signed [ANG_W-1:0] v;
		case (idx)
			0:  v = 35'sd843314857;
			1:  v = 35'sd497837829;
			2:  v = 35'sd263043837;
			3:  v = 35'sd133525159;
			4:  v = 35'sd67021687;
			5:  v = 35'sd33543516;
			6:  v = 35'sd16775851;
			7:  v = 35'sd8388437;
			8:  v = 35'sd4194283;
			9:  v = 35'sd2097149;
			10: v = 35'sd1048576;
			11: v = 35'sd524288;
			12: v = 35'sd262144;
			13: v = 35'sd131072;
			14: v = 35'sd65536;
			15: v = 35'sd32768;
			16: v = 35'sd16384;
			17: v = 35'sd8192;
			18: v = 35'sd4096;
			19: v = 35'sd2048;
			20: v = 35'sd1024;
			21: v = 35'sd512;
			22: v = 35'sd256;
			23: v = 35'sd128;
			24: v = 35'sd64;
			25: v = 35'sd32;
			26: v = 35'sd16;
			27: v = 35'sd8;
			28: v = 35'sd4;
			29: v = 35'sd2;
			default: v = '0;
		endcase
		return v;
	endfunction

	// clamp a rotation result to [-1.0, 1.0] in Q2.30
	function automatic logic signed [XW-1:0] clamp_q30(input logic signed [ROT_W-1:0] v);
		logic signed [XW-1:0] r;
		if (v > ROT_W'(Q30_ONE))
			r = Q30_ONE;
		else if (v < -ROT_W'(Q30_ONE))
			r = -Q30_ONE;
		else
			r = v[XW-1:0];
		return r;
	endfunction

	// saturate a wide sum to signed 32 bits
	function automatic logic signed [XW-1:0] sat_q16(input logic signed [SUM_W-1:0] v);
		logic signed [XW-1:0] r;
		if (v > SUM_W'(32'sh7FFF_FFFF))
			r = 32'sh7FFF_FFFF;
		else if (v < -SUM_W'(48'sh0000_8000_0000))
			r = 32'sh8000_0000;
		else
			r = v[XW-1:0];
		return r;
	endfunction

endpackage

FILE: rtl/wpv_delay.sv
// Enable-gated shift line that carries side data alongside the arithmetic cells.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
module wpv_delay #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);

	logic [WIDTH-1:0] tap_q [DEPTH];

	// advance every tap by one stage
	always_ff @(posedge clk) begin
		if (en) begin
			tap_q[0] <= d;
			for (int i = 1; i < DEPTH; i++)
				tap_q[i] <= tap_q[i-1];
		end
	end

	assign q = tap_q[DEPTH-1];

endmodule

FILE: rtl/wpv_cordic_cell.sv
// One registered CORDIC micro-rotation, vectoring or rotation mode.
// Depends on wpv_pkg for the arctangent table and angle width.
`timescale 1ns / 1ps
module wpv_cordic_cell #(
	parameter wpv_pkg::cordic_mode_t MODE = wpv_pkg::CORDIC_VEC,
	parameter int STEP = 0,
	parameter int W    = 66
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic signed [W-1:0]              x_in,
	input  logic signed [W-1:0]              y_in,
	input  logic signed [wpv_pkg::ANG_W-1:0] z_in,
	output logic signed [W-1:0]              x_q,
	output logic signed [W-1:0]              y_q,
	output logic signed [wpv_pkg::ANG_W-1:0] z_q
);
	import wpv_pkg::*;

	logic signed [W-1:0]     xsh, ysh, x_nxt, y_nxt;
	logic signed [ANG_W-1:0] z_nxt, step_ang;
	logic                    pos;

	// pick the direction and rotate by the step angle
	always_comb begin
		xsh      = x_in >>> STEP;
		ysh      = y_in >>> STEP;
		step_ang = atan_q30(STEP);
		if (MODE == CORDIC_VEC)
			pos = (y_in > 0);
		else
			pos = z_in[ANG_W-1];
		if (pos) begin
			x_nxt = x_in + ysh;
			y_nxt = y_in - xsh;
			z_nxt = z_in + step_ang;
		end else begin
			x_nxt = x_in - ysh;
			y_nxt = y_in + xsh;
			z_nxt = z_in - step_ang;
		end
	end

	// hand the result to the next cell
	always_ff @(posedge clk) begin
		if (en) begin
			x_q <= x_nxt;
			y_q <= y_nxt;
			z_q <= z_nxt;
		end
	end

endmodule

FILE: rtl/wpv_root_cell.sv
// One registered digit of a restoring integer square root.
// Depends on wpv_pkg for the operand widths.
`timescale 1ns / 1ps
module wpv_root_cell #(
	parameter int K = 0
) (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic [wpv_pkg::SQ_W-1:0]      rem_in,
	input  logic [wpv_pkg::ROOT_BITS-1:0] root_in,
	output logic [wpv_pkg::SQ_W-1:0]      rem_q,
	output logic [wpv_pkg::ROOT_BITS-1:0] root_q
);
	import wpv_pkg::*;

	localparam int TW = SQ_W + 2;

	logic [TW-1:0] trial;
	logic          fits;

	// trial subtrahend for setting bit K of the root
	always_comb begin
		trial = (TW'(root_in) << (K + 1)) + (TW'(1) << (2 * K));
		fits  = TW'(rem_in) >= trial;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= fits ? rem_in - trial[SQ_W-1:0] : rem_in;
			root_q <= fits ? root_in | (ROOT_BITS'(1) << K) : root_in;
		end
	end

endmodule

FILE: rtl/wpv_div_cell.sv
// One registered quotient bit of a restoring unsigned divider.
// Depends on wpv_pkg for the operand widths.
`timescale 1ns / 1ps
module wpv_div_cell #(
	parameter int K = 0
) (
	input  logic                               clk,
	input  logic                               en,
	input  logic [wpv_pkg::NUM_W-1:0]    rem_in,
	input  logic [wpv_pkg::DEN_W-1:0]    den_in,
	input  logic [wpv_pkg::QUO_BITS-1:0] quo_in,
	output logic [wpv_pkg::NUM_W-1:0]    rem_q,
	output logic [wpv_pkg::DEN_W-1:0]    den_q,
	output logic [wpv_pkg::QUO_BITS-1:0] quo_q
);
	import wpv_pkg::*;

	localparam int TW = DEN_W + QUO_BITS;

	logic [TW-1:0] trial;
	logic          fits;

	// shifted divisor against the partial remainder
	always_comb begin
		trial = TW'(den_in) << K;
		fits  = TW'(rem_in) >= trial;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= fits ? rem_in - trial[NUM_W-1:0] : rem_in;
			den_q <= den_in;
			quo_q <= fits ? quo_in | (QUO_BITS'(1) << K) : quo_in;
		end
	end

endmodule

FILE: rtl/wdisc_point_variation_top.sv
// Top level of the wdisc point variation block: a pipeline of CORDIC, root and divider cells.
// Depends on wpv_pkg, wpv_delay, wpv_cordic_cell, wpv_root_cell and wpv_div_cell.
`timescale 1ns / 1ps
// Takes one word (tx, ty, tz, px_in, py_in, pz_in) per clock and returns one word
// (px_out, py_out, pz_out) for each word it accepts, all signed Q16.16. Every
// arithmetic step is a cell of its own: 30 vectoring CORDIC cells for the angle, 32 square
// root cells, 32 divider cells for pi / (radius + 1) and 30 rotating CORDIC cells for sin
// and cos, so the sustained rate is one word per cycle. The whole pipeline advances together
// and halts only while a result sits in the output register and out_stall is high.
// amount is written through cfg_we / cfg_wdata and resets to 1.0.
module wdisc_point_variation_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [wpv_pkg::XW-1:0]             cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [wpv_pkg::XW-1:0]      tx,
	input  logic signed [wpv_pkg::XW-1:0]      ty,
	input  logic signed [wpv_pkg::XW-1:0]      tz,
	input  logic signed [wpv_pkg::XW-1:0]      px_in,
	input  logic signed [wpv_pkg::XW-1:0]      py_in,
	input  logic signed [wpv_pkg::XW-1:0]      pz_in,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [wpv_pkg::XW-1:0]      px_out,
	output logic signed [wpv_pkg::XW-1:0]      py_out,
	output logic signed [wpv_pkg::XW-1:0]      pz_out
);
	import wpv_pkg::*;

	localparam int LAST = 101;
	localparam int PW   = $bits(payload_t);

	logic             adv;
	logic [LAST:1]    v_q;
	logic signed [XW-1:0] amount_q;

	// stage 1: input word
	logic signed [XW-1:0] tx_s1, ty_s1, tz_s1, px_s1, py_s1, pz_s1;
	logic signed [SQ_W-1:0]  xx_c, yy_c;
	logic signed [VEC_W-1:0] vx_c, vy_c;
	logic signed [ANG_W-1:0] va_c;
	logic                    xneg_c;

	// stage 2 and 3: squares, CORDIC seed, sum of squares
	logic [SQ_W-1:0]         xx_s2, yy_s2, n_s3;
	logic signed [VEC_W-1:0] vx_s2, vy_s2;
	logic signed [ANG_W-1:0] va_s2;

	logic signed [VEC_W-1:0] vx [CORDIC_STEPS+1];
	logic signed [VEC_W-1:0] vy [CORDIC_STEPS+1];
	logic signed [ANG_W-1:0] va [CORDIC_STEPS+1];

	logic [SQ_W-1:0]      rem [ROOT_BITS+1];
	logic [ROOT_BITS-1:0] root [ROOT_BITS+1];

	logic [NUM_W-1:0]    drem [QUO_BITS+1];
	logic [DEN_W-1:0]    dden [QUO_BITS+1];
	logic [QUO_BITS-1:0] dquo [QUO_BITS+1];

	logic signed [ROT_W-1:0] rx [CORDIC_STEPS+1];
	logic signed [ROT_W-1:0] ry [CORDIC_STEPS+1];
	logic signed [ANG_W-1:0] rz [CORDIC_STEPS+1];

	logic signed [ANG_W+29:0] ap_s33;
	logic signed [ANG_W+29:0] ar_rnd;
	logic signed [XW-1:0]     r_c, r_s34, r_d67, r_d98;
	logic [1:0]               flags_d33;
	logic [QUO_BITS-1:0]      a_c;
	logic signed [ANG_W-1:0]  rz_s68;

	payload_t pay_s1, pay_d99;

	logic signed [XW-1:0]     ca_s99, sa_s99;
	logic signed [2*XW-1:0]   ar_s99, t_full;
	logic signed [XW:0]       t_c;
	logic signed [2*XW:0]     xprod_s100, yprod_s100, xsh_c, ysh_c;
	logic signed [2*XW-1:0]   zprod_s100, zsh_c;
	logic signed [XW-1:0]     px_s100, py_s100, pz_s100;
	logic signed [SUM_W-1:0]  xsum_c, ysum_c, zsum_c;

	// advance unless a finished word waits on a stalled receiver
	assign adv       = !v_q[LAST] || !out_stall;
	assign in_stall  = !adv;
	assign out_valid = v_q[LAST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[LAST-1:1], in_valid};
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amount_q <= AMOUNT_RESET;
		end else if (cfg_we) begin
			amount_q <= cfg_wdata;
		end
	end

	// stage 1: capture the word
	always_ff @(posedge clk) begin
		if (adv) begin
			tx_s1 <= tx;
			ty_s1 <= ty;
			tz_s1 <= tz;
			px_s1 <= px_in;
			py_s1 <= py_in;
			pz_s1 <= pz_in;
		end
	end

	// squares and the vectoring seed, folded into the right half plane
	always_comb begin
		xx_c   = tx_s1 * tx_s1;
		yy_c   = ty_s1 * ty_s1;
		xneg_c = tx_s1[XW-1];
		vx_c   = VEC_W'(tx_s1) <<< 30;
		vy_c   = VEC_W'(ty_s1) <<< 30;
		va_c   = '0;
		if (xneg_c) begin
			vx_c = -vx_c;
			vy_c = -vy_c;
			va_c = (ty_s1 > 0) ? PI_Q30 : -PI_Q30;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xx_s2 <= xx_c;
			yy_s2 <= yy_c;
			vx_s2 <= vx_c;
			vy_s2 <= vy_c;
			va_s2 <= va_c;
			n_s3  <= xx_s2 + yy_s2;
		end
	end

	// angle of the point: vectoring cells
	assign vx[0] = vx_s2;
	assign vy[0] = vy_s2;
	assign va[0] = va_s2;

	for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_vec
		wpv_cordic_cell #(
			.MODE (CORDIC_VEC),
			.STEP (j),
			.W    (VEC_W)
		) u_cell (
			.clk  (clk),
			.en   (adv),
			.x_in (vx[j]),
			.y_in (vy[j]),
			.z_in (va[j]),
			.x_q  (vx[j+1]),
			.y_q  (vy[j+1]),
			.z_q  (va[j+1])
		);
	end

	// axis flags travel beside the vectoring cells
	wpv_delay #(
		.WIDTH (2),
		.DEPTH (32)
	) u_flag_dly (
		.clk (clk),
		.en  (adv),
		.d   ({ty_s1 == '0, xneg_c}),
		.q   (flags_d33)
	);

	// angle over pi, rounded and clamped; the x axis is exact
	always_comb begin
		ar_rnd = (ap_s33 + (65'sd1 <<< 29)) >>> 30;
		if (flags_d33[1])
			r_c = flags_d33[0] ? Q30_ONE : '0;
		else if (ar_rnd > 65'(Q30_ONE))
			r_c = Q30_ONE;
		else if (ar_rnd < -65'(Q30_ONE))
			r_c = -Q30_ONE;
		else
			r_c = ar_rnd[XW-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ap_s33 <= va[CORDIC_STEPS] * INV_PI_Q30;
			r_s34  <= r_c;
		end
	end

	// radius: square root cells
	assign rem[0]  = n_s3;
	assign root[0] = '0;

	for (genvar j = 0; j < ROOT_BITS; j++) begin : g_root
		wpv_root_cell #(
			.K (ROOT_BITS - 1 - j)
		) u_cell (
			.clk     (clk),
			.en      (adv),
			.rem_in  (rem[j]),
			.root_in (root[j]),
			.rem_q   (rem[j+1]),
			.root_q  (root[j+1])
		);
	end

	// pi / (radius + 1) with rounding: divider cells
	assign dden[0] = DEN_W'(root[ROOT_BITS]) + DEN_W'(32'h0001_0000);
	assign drem[0] = (NUM_W'(PI_Q30[XW-1:0]) << 16) + NUM_W'(dden[0] >> 1);
	assign dquo[0] = '0;

	for (genvar j = 0; j < QUO_BITS; j++) begin : g_div
		wpv_div_cell #(
			.K (QUO_BITS - 1 - j)
		) u_cell (
			.clk    (clk),
			.en     (adv),
			.rem_in (drem[j]),
			.den_in (dden[j]),
			.quo_in (dquo[j]),
			.rem_q  (drem[j+1]),
			.den_q  (dden[j+1]),
			.quo_q  (dquo[j+1])
		);
	end

	wpv_delay #(
		.WIDTH (XW),
		.DEPTH (33)
	) u_r_dly_a (
		.clk (clk),
		.en  (adv),
		.d   (r_s34),
		.q   (r_d67)
	);

	// reflect the disc angle for a positive ratio, then shift by a quarter turn
	assign a_c = (r_d67 > 0) ? PI_Q30[XW-1:0] - dquo[QUO_BITS] : dquo[QUO_BITS];

	always_ff @(posedge clk) begin
		if (adv) begin
			rz_s68 <= $signed(ANG_W'(a_c)) - HALF_PI_Q30;
		end
	end

	// sine and cosine: rotating cells
	assign rx[0] = GAIN_INV_Q30;
	assign ry[0] = '0;
	assign rz[0] = rz_s68;

	for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_rot
		wpv_cordic_cell #(
			.MODE (CORDIC_ROT),
			.STEP (j),
			.W    (ROT_W)
		) u_cell (
			.clk  (clk),
			.en   (adv),
			.x_in (rx[j]),
			.y_in (ry[j]),
			.z_in (rz[j]),
			.x_q  (rx[j+1]),
			.y_q  (ry[j+1]),
			.z_q  (rz[j+1])
		);
	end

	wpv_delay #(
		.WIDTH (XW),
		.DEPTH (31)
	) u_r_dly_b (
		.clk (clk),
		.en  (adv),
		.d   (r_d67),
		.q   (r_d98)
	);

	// running point and z travel to the final adders
	assign pay_s1 = '{tz: tz_s1, px: px_s1, py: py_s1, pz: pz_s1};

	wpv_delay #(
		.WIDTH (PW),
		.DEPTH (98)
	) u_pay_dly (
		.clk (clk),
		.en  (adv),
		.d   (pay_s1),
		.q   (pay_d99)
	);

	// weights, products and rounded sums
	always_comb begin
		t_full = (ar_s99 + 64'sd536870912) >>> 30;
		t_c    = t_full[XW:0];
		xsh_c  = (xprod_s100 + (65'sd1 <<< 29)) >>> 30;
		ysh_c  = (yprod_s100 + (65'sd1 <<< 29)) >>> 30;
		zsh_c  = (zprod_s100 + 64'sd32768) >>> 16;
		xsum_c = SUM_W'(px_s100) + $signed(xsh_c[SUM_W-1:0]);
		ysum_c = SUM_W'(py_s100) + $signed(ysh_c[SUM_W-1:0]);
		zsum_c = SUM_W'(pz_s100) + $signed(zsh_c[SUM_W-1:0]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ca_s99     <= clamp_q30(-ry[CORDIC_STEPS]);
			sa_s99     <= clamp_q30(rx[CORDIC_STEPS]);
			ar_s99     <= amount_q * r_d98;
			xprod_s100 <= t_c * ca_s99;
			yprod_s100 <= t_c * sa_s99;
			zprod_s100 <= amount_q * pay_d99.tz;
			px_s100    <= pay_d99.px;
			py_s100    <= pay_d99.py;
			pz_s100    <= pay_d99.pz;
			px_out     <= sat_q16(xsum_c);
			py_out     <= sat_q16(ysum_c);
			pz_out     <= sat_q16(zsum_c);
		end
	end

endmodule

FILE: rtl/wpv_port_checker.sv
// Port-level assertions for the wdisc point variation block, bound to its top level.
// Depends on wdisc_point_variation_top_assert.svh and wpv_pkg.
`timescale 1ns / 1ps
`include "wdisc_point_variation_top_assert.svh"
module wpv_port_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic signed [wpv_pkg::XW-1:0] px_out,
	input logic signed [wpv_pkg::XW-1:0] pz_out
);

	// input is held back only by a stalled output word
	`WPV_ASSERT(a_stall_cause, in_stall |-> (out_valid && out_stall), "in_stall without stalled output")

	// an empty output register always lets a word in
	`WPV_ASSERT(a_empty_takes, !out_valid |-> !in_stall, "input stalled while output empty")

	// a waiting word stays and holds px_out and pz_out
	`WPV_ASSERT(a_out_keep, (out_valid && out_stall) |=> out_valid, "output word dropped while stalled")
	`WPV_ASSERT_HOLD(a_px_hold, px_out, "px_out changed while stalled")
	`WPV_ASSERT_HOLD(a_pz_hold, pz_out, "pz_out changed while stalled")

endmodule

bind wdisc_point_variation_top wpv_port_checker u_port_checker (.*);
